### sv/srt_pkg.sv
// Shared types and constants for the shortest-remaining-time scheduler.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
package srt_pkg;

  // Default table size and the job id width.
  localparam int MAX_JOBS_DEF = 16;
  localparam int ID_W         = 8;
  localparam int TIME_W       = 32;
  localparam int LEN_W        = 16;

  // Input function codes.
  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_RUN = 1'b1;

  // Global values that every cell sees during a scan.
  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic              cur_valid;
    logic [ID_W-1:0]   cur_id;
  } ctl_t;

  // Best candidate so far, handed from one cell to the next.
  typedef struct packed {
    logic              vld;
    logic              found;
    logic [ID_W-1:0]   pick;
    logic [LEN_W-1:0]  best;
    logic [TIME_W-1:0] arrival;
    logic [LEN_W-1:0]  length;
    logic [TIME_W-1:0] start;
    logic              started;
  } scan_t;

  // Table update broadcast to all cells; only the addressed cell takes it.
  typedef struct packed {
    logic              add_en;
    logic              run_en;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  rem;
    logic              set_start;
    logic [TIME_W-1:0] start;
    logic              set_done;
  } wr_t;

  // Result word.
  typedef struct packed {
    logic [3:0]        job_id;
    logic              table_full;
    logic [TIME_W-1:0] slice_start;
    logic [TIME_W-1:0] job_arrival;
    logic [LEN_W-1:0]  ran_for;
    logic              idle;
    logic              finished;
    logic [TIME_W-1:0] response_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] wait_time;
    logic              all_done;
  } res_t;

  // Saturating add and subtract of times.
  function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] sat_sub(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

endpackage

### sv/srt_if.sv
// Valid/ready channel interfaces for the scheduler's input and result words.
// Depends on srt_pkg for field widths.
`timescale 1ns / 1ps
interface srt_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [srt_pkg::TIME_W-1:0] arrival_time;
  logic [srt_pkg::LEN_W-1:0]  job_length;
  modport source (output valid, func, arrival_time, job_length, input ready);
  modport sink   (input valid, func, arrival_time, job_length, output ready);
endinterface

interface srt_out_if;
  logic                      valid;
  logic                      ready;
  logic [3:0]                job_id;
  logic                      table_full;
  logic [srt_pkg::TIME_W-1:0] slice_start;
  logic [srt_pkg::TIME_W-1:0] job_arrival;
  logic [srt_pkg::LEN_W-1:0]  ran_for;
  logic                      idle;
  logic                      finished;
  logic [srt_pkg::TIME_W-1:0] response_time;
  logic [srt_pkg::TIME_W-1:0] turnaround_time;
  logic [srt_pkg::TIME_W-1:0] wait_time;
  logic                      all_done;
  modport source (output valid, job_id, table_full, slice_start, job_arrival, ran_for, idle,
                  finished, response_time, turnaround_time, wait_time, all_done,
                  input ready);
  modport sink   (input valid, job_id, table_full, slice_start, job_arrival, ran_for, idle,
                  finished, response_time, turnaround_time, wait_time, all_done,
                  output ready);
endinterface

### sv/srt_cell.sv
// One job slot of the scheduler chain: holds the job and compares it with
// the candidate handed in from the previous slot. Depends on srt_pkg.
`timescale 1ns / 1ps
module srt_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [srt_pkg::ID_W-1:0]   my_id,
  input  srt_pkg::ctl_t              ctl,
  input  srt_pkg::wr_t               wr,
  input  srt_pkg::scan_t             scan_in,
  output srt_pkg::scan_t             scan_out,
  output logic                       settled
);

  logic                          used;
  logic                          done;
  logic                          started;
  logic [srt_pkg::TIME_W-1:0]    arrival;
  logic [srt_pkg::LEN_W-1:0]     length;
  logic [srt_pkg::LEN_W-1:0]     rem;
  logic [srt_pkg::TIME_W-1:0]    start;
  logic                          hit;
  logic                          elig;
  logic                          take;
  srt_pkg::scan_t                scan_next;

  assign hit     = (wr.id == my_id);
  assign settled = !used || done;

  // This slot wins on a smaller remaining time, or on a tie when it is the
  // job that ran last.
  always_comb begin
    elig = used && !done && (arrival <= ctl.now);
    take = elig && (!scan_in.found || (rem < scan_in.best) ||
                    ((rem == scan_in.best) && ctl.cur_valid && (ctl.cur_id == my_id)));
    scan_next = scan_in;
    if (take) begin
      scan_next.found   = 1'b1;
      scan_next.pick    = my_id;
      scan_next.best    = rem;
      scan_next.arrival = arrival;
      scan_next.length  = length;
      scan_next.start   = start;
      scan_next.started = started;
    end
  end

  // Slot flags and the candidate handed on.
  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= 1'b0;
      done     <= 1'b0;
      started  <= 1'b0;
      scan_out <= '0;
    end else begin
      scan_out <= scan_next;
      if (wr.add_en && hit) begin
        used    <= 1'b1;
        done    <= 1'b0;
        started <= 1'b0;
      end else if (wr.run_en && hit) begin
        if (wr.set_start) started <= 1'b1;
        if (wr.set_done)  done    <= 1'b1;
      end
    end
  end

  // Slot data.
  always_ff @(posedge clk) begin
    if (wr.add_en && hit) begin
      arrival <= wr.arrival;
      length  <= wr.length;
      rem     <= wr.length;
      start   <= '0;
    end else if (wr.run_en && hit) begin
      rem <= wr.rem;
      if (wr.set_start) start <= wr.start;
    end
  end

endmodule

### sv/shortest_remaining_time_scheduler_top.sv
// A run word's pick travels one job slot per cycle along a chain of slots,
// then the S_CALC and S_TURN states work out the run length and the
// saturated times before S_EMIT registers the result once the output
// register is free. An add word goes straight to S_EMIT. One word is in
// work at a time; a finished result waits in the output register without
// holding up the next input word. The quantum is written through
// cfg_we/cfg_wdata; a quantum of zero acts as one. Depends on srt_pkg, srt_if and srt_cell.
`timescale 1ns / 1ps
module shortest_remaining_time_scheduler_top #(
  parameter int MAX_JOBS = srt_pkg::MAX_JOBS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  srt_in_if.sink                     in_ch,
  srt_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [srt_pkg::LEN_W-1:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CALC, S_TURN, S_EMIT} state_t;

  state_t                      state;
  logic [srt_pkg::LEN_W-1:0]   quantum;
  logic [CNT_W-1:0]            job_count;
  logic [srt_pkg::ID_W-1:0]    cur_id;
  logic                        cur_valid;
  logic [srt_pkg::TIME_W-1:0]  clock_now;
  logic                        op_run;
  logic [srt_pkg::TIME_W-1:0]  in_arr;
  logic [srt_pkg::LEN_W-1:0]   in_len;
  srt_pkg::scan_t              pick;
  logic [srt_pkg::LEN_W-1:0]   ran;
  logic [srt_pkg::LEN_W-1:0]   rem_new;
  logic [srt_pkg::TIME_W-1:0]  done_at;
  logic [srt_pkg::TIME_W-1:0]  turn;
  logic [srt_pkg::TIME_W-1:0]  resp;
  srt_pkg::res_t               res;
  srt_pkg::res_t               res_next;
  logic                        res_valid;

  srt_pkg::ctl_t               ctl;
  srt_pkg::wr_t                wr;
  srt_pkg::scan_t              seed;
  srt_pkg::scan_t              chain [MAX_JOBS+1];
  logic [MAX_JOBS-1:0]         settled;
  logic [MAX_JOBS-1:0]         settled_adj;
  logic [srt_pkg::LEN_W-1:0]   q_eff;
  logic                        in_acc;
  logic                        emit_go;
  logic                        fin;
  logic                        full;

  assign q_eff   = (quantum == '0) ? srt_pkg::LEN_W'(1) : quantum;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign emit_go = (state == S_EMIT) && (!res_valid || out_ch.ready);
  assign fin     = pick.found && (rem_new == '0);
  assign full    = (job_count == CNT_W'(MAX_JOBS));

  assign ctl.now       = clock_now;
  assign ctl.cur_valid = cur_valid;
  assign ctl.cur_id    = cur_id;

  // A fresh, empty candidate enters the first slot when a run word arrives.
  always_comb begin
    seed       = '0;
    seed.vld   = in_acc && (in_ch.func == srt_pkg::FUNC_RUN);
    chain[0]   = seed;
  end

  // Chain of job slots.
  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    srt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .my_id    (srt_pkg::ID_W'(i)),
      .ctl      (ctl),
      .wr       (wr),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1]),
      .settled  (settled[i])
    );
    assign settled_adj[i] = settled[i] ||
                            (op_run && fin && (pick.pick == srt_pkg::ID_W'(i)));
  end

  // Table update issued together with the result.
  always_comb begin
    wr           = '0;
    wr.add_en    = emit_go && !op_run && !full;
    wr.run_en    = emit_go && op_run && pick.found;
    wr.id        = op_run ? pick.pick : srt_pkg::ID_W'(job_count);
    wr.arrival   = in_arr;
    wr.length    = in_len;
    wr.rem       = rem_new;
    wr.set_start = !pick.started;
    wr.start     = clock_now;
    wr.set_done  = fin;
  end

  // Result word for the operation in work.
  always_comb begin
    res_next = '0;
    if (!op_run) begin
      if (full) begin
        res_next.table_full = 1'b1;
        res_next.all_done   = &settled;
      end else begin
        res_next.job_id = 4'(job_count);
      end
    end else begin
      res_next.slice_start = clock_now;
      res_next.all_done    = &settled_adj;
      if (!pick.found) begin
        res_next.idle = 1'b1;
      end else begin
        res_next.job_id      = 4'(pick.pick);
        res_next.job_arrival = pick.arrival;
        res_next.ran_for     = ran;
        if (fin) begin
          res_next.finished        = 1'b1;
          res_next.response_time   = resp;
          res_next.turnaround_time = turn;
          res_next.wait_time       = srt_pkg::sat_sub(turn, srt_pkg::TIME_W'(pick.length));
        end
      end
    end
  end

  // Control sequence, table bookkeeping and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      quantum   <= srt_pkg::LEN_W'(1);
      job_count <= '0;
      cur_id    <= '0;
      cur_valid <= 1'b0;
      clock_now <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) quantum <= cfg_wdata;
      if (emit_go) res_valid <= 1'b1;
      else if (out_ch.ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            op_run <= (in_ch.func == srt_pkg::FUNC_RUN);
            in_arr <= in_ch.arrival_time;
            in_len <= in_ch.job_length;
            state  <= (in_ch.func == srt_pkg::FUNC_RUN) ? S_SCAN : S_EMIT;
          end
        end
        S_SCAN: begin
          if (chain[MAX_JOBS].vld) begin
            pick  <= chain[MAX_JOBS];
            state <= S_CALC;
          end
        end
        S_CALC: begin
          ran     <= (pick.best < q_eff) ? pick.best : q_eff;
          rem_new <= pick.best - ((pick.best < q_eff) ? pick.best : q_eff);
          done_at <= srt_pkg::sat_add(clock_now,
                       srt_pkg::TIME_W'((pick.best < q_eff) ? pick.best : q_eff));
          state   <= S_TURN;
        end
        S_TURN: begin
          turn  <= srt_pkg::sat_sub(done_at, pick.arrival);
          resp  <= srt_pkg::sat_sub(pick.started ? pick.start : clock_now, pick.arrival);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            res   <= res_next;
            state <= S_IDLE;
            if (!op_run) begin
              if (!full) job_count <= job_count + CNT_W'(1);
            end else begin
              clock_now <= srt_pkg::sat_add(clock_now, srt_pkg::TIME_W'(q_eff));
              if (pick.found) begin
                if (fin) begin
                  cur_valid <= 1'b0;
                end else begin
                  cur_id    <= pick.pick;
                  cur_valid <= 1'b1;
                end
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Port drive.
  assign in_ch.ready            = (state == S_IDLE);
  assign out_ch.valid           = res_valid;
  assign out_ch.job_id          = res.job_id;
  assign out_ch.table_full      = res.table_full;
  assign out_ch.slice_start     = res.slice_start;
  assign out_ch.job_arrival     = res.job_arrival;
  assign out_ch.ran_for         = res.ran_for;
  assign out_ch.idle            = res.idle;
  assign out_ch.finished        = res.finished;
  assign out_ch.response_time   = res.response_time;
  assign out_ch.turnaround_time = res.turnaround_time;
  assign out_ch.wait_time       = res.wait_time;
  assign out_ch.all_done        = res.all_done;

  // A candidate leaves the chain only while a scan is in progress.
  a_chain_scan: assert property (@(posedge clk) disable iff (rst)
    chain[MAX_JOBS].vld |-> (state == S_SCAN))
    else $error("candidate left the chain outside a scan");

  // A finished job cannot be an idle quantum.
  a_fin_not_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.finished) |-> !res.idle)
    else $error("finished and idle reported together");

  // Turnaround never falls below response for a finished job.
  a_turn_ge_resp: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.finished) |-> (res.turnaround_time >= res.response_time))
    else $error("turnaround below response time");

endmodule
